// ===== hdl/percent_escape_decoder_top_macros.svh =====
// Assertion macros for the percent escape decoder.
`ifndef PERCENT_ESCAPE_DECODER_TOP_MACROS_SVH
`define PERCENT_ESCAPE_DECODER_TOP_MACROS_SVH

`ifndef SYNTH
`define PED_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PED_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define PED_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ===== hdl/ped_pkg.sv =====
`timescale 1ns / 1ps
package ped_pkg;

    localparam int unsigned ESC_COUNT = 21;
    localparam int unsigned QDEPTH    = 4;
    localparam int unsigned QPTR_W    = $clog2(QDEPTH);
    localparam int unsigned QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [7:0] PERCENT_CHAR = 8'h25;

    localparam logic [7:0] ESC_HI [ESC_COUNT] = '{
        8'h32, 8'h32, 8'h32, 8'h32, 8'h32, 8'h32, 8'h32, 8'h32, 8'h32, 8'h32,
        8'h32, 8'h32, 8'h32, 8'h32, 8'h33, 8'h33, 8'h33, 8'h33, 8'h34, 8'h35,
        8'h35
    };
    localparam logic [7:0] ESC_LO [ESC_COUNT] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
        8'h41, 8'h42, 8'h43, 8'h46, 8'h41, 8'h42, 8'h44, 8'h46, 8'h30, 8'h42,
        8'h44
    };
    localparam logic [7:0] ESC_VAL [ESC_COUNT] = '{
        8'h20, 8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28, 8'h29,
        8'h2A, 8'h2B, 8'h2C, 8'h2F, 8'h3A, 8'h3B, 8'h3D, 8'h3F, 8'h40, 8'h5B,
        8'h5D
    };

    typedef enum logic [1:0] {
        HOLD_NONE = 2'd0,
        HOLD_PCT  = 2'd1,
        HOLD_TWO  = 2'd2
    } t_hold;

    typedef struct packed {
        logic [1:0]      cnt;
        logic            last;
        logic [2:0][7:0] data;
    } t_entry;

    typedef struct packed {
        logic              empty;
        logic              full;
        logic [QCNT_W-1:0] count;
    } t_qstat;

    typedef struct packed {
        t_hold hold;
    } t_fstat;

    // Returns the match flag in the top bit and the decoded character below it.
    function automatic logic [8:0] esc_lookup(input logic [7:0] hi, input logic [7:0] lo);
        logic [8:0] res;
        res = '0;
        for (int i = 0; i < ESC_COUNT; i++) begin
            if (!res[8] && ESC_HI[i] == hi && ESC_LO[i] == lo) begin
                res = {1'b1, ESC_VAL[i]};
            end
        end
        return res;
    endfunction

endpackage

// ===== hdl/percent_escape_decoder_top.sv =====
`timescale 1ns / 1ps
// Percent escape decoder: takes one encoded byte per request and returns the decoded
// bytes, marking the final decoded byte of each string with tlast. A '%' and the two
// bytes after it are replaced by the reserved character they name when they form one
// of the 21 uppercase escapes from %20 to %5D; otherwise the '%' is passed on and the
// held bytes are examined again. Each input request causes zero to three output
// requests. The input side takes one request per cycle while the four-entry queue
// between the decoding front and the output stage has room; the output stage sends one
// byte per cycle while the receiver is ready, so a request that yields n bytes keeps
// the output until its n bytes are taken. The input stalls only when the queue is
// full, which happens when expansions or a stalled receiver let entries build up. A
// decoded byte is written into the queue, then into the output stage's entry register.
module percent_escape_decoder_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic       i_s_tlast,
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [7:0] out_byte
    output logic       o_m_tlast
);
    import ped_pkg::*;

    `include "percent_escape_decoder_top_macros.svh"

    logic   w_push, w_pop;
    t_entry w_entry, w_head;
    t_qstat w_qstat;
    t_fstat w_fstat;

    ped_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_byte  (i_s_tdata),
        .i_last  (i_s_tlast),
        .o_ready (o_s_tready),
        .i_full  (w_qstat.full),
        .o_push  (w_push),
        .o_entry (w_entry),
        .o_stat  (w_fstat)
    );

    ped_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_entry),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_qstat)
    );

    ped_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (w_head),
        .i_empty (w_qstat.empty),
        .o_pop   (w_pop),
        .o_valid (o_m_tvalid),
        .i_ready (i_m_tready),
        .o_data  (o_m_tdata),
        .o_last  (o_m_tlast)
    );

    `PED_ASSERT_NOW(a_queue_bound, i_clk, i_rst_n, 1'b1, w_qstat.count <= QCNT_W'(QDEPTH), "queue count beyond depth")
    `PED_ASSERT_NOW(a_full_stalls, i_clk, i_rst_n, w_qstat.full, !o_s_tready, "input taken while queue full")
    `PED_ASSERT_NEXT(a_last_flushes, i_clk, i_rst_n, i_s_tvalid && o_s_tready && i_s_tlast, w_fstat.hold == HOLD_NONE, "bytes still held after final byte")
    `PED_ASSERT_NOW(a_push_room, i_clk, i_rst_n, w_push, !w_qstat.full, "push into full queue")

endmodule

// ===== hdl/ped_front.sv =====
`timescale 1ns / 1ps
module ped_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_byte,
    input  logic            i_last,
    output logic            o_ready,
    input  logic            i_full,
    output logic            o_push,
    output ped_pkg::t_entry o_entry,
    output ped_pkg::t_fstat o_stat
);
    import ped_pkg::*;

    t_hold      r_hold, n_hold;
    logic [7:0] r_second, n_second;
    logic       w_accept;
    logic [8:0] w_lookup;
    t_entry     w_entry;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && !i_full;
    assign w_lookup = esc_lookup(r_second, i_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= HOLD_NONE;
        end else if (w_accept) begin
            r_hold <= n_hold;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_second <= n_second;
        end
    end

    always_comb begin
        n_hold       = r_hold;
        n_second     = r_second;
        w_entry      = '0;
        w_entry.last = i_last;
        unique case (r_hold)
            HOLD_PCT: begin
                if (i_last) begin
                    w_entry.cnt     = 2'd2;
                    w_entry.data[0] = PERCENT_CHAR;
                    w_entry.data[1] = i_byte;
                    n_hold          = HOLD_NONE;
                end else begin
                    n_second = i_byte;
                    n_hold   = HOLD_TWO;
                end
            end
            HOLD_TWO: begin
                if (w_lookup[8]) begin
                    w_entry.cnt     = 2'd1;
                    w_entry.data[0] = w_lookup[7:0];
                    n_hold          = HOLD_NONE;
                end else begin
                    w_entry.data[0] = PERCENT_CHAR;
                    if (r_second == PERCENT_CHAR) begin
                        if (i_last) begin
                            w_entry.cnt     = 2'd3;
                            w_entry.data[1] = PERCENT_CHAR;
                            w_entry.data[2] = i_byte;
                            n_hold          = HOLD_NONE;
                        end else begin
                            w_entry.cnt = 2'd1;
                            n_second    = i_byte;
                            n_hold      = HOLD_TWO;
                        end
                    end else begin
                        w_entry.data[1] = r_second;
                        if (i_byte == PERCENT_CHAR && !i_last) begin
                            w_entry.cnt = 2'd2;
                            n_hold      = HOLD_PCT;
                        end else begin
                            w_entry.cnt     = 2'd3;
                            w_entry.data[2] = i_byte;
                            n_hold          = HOLD_NONE;
                        end
                    end
                end
            end
            default: begin
                if (i_byte == PERCENT_CHAR && !i_last) begin
                    n_hold = HOLD_PCT;
                end else begin
                    w_entry.cnt     = 2'd1;
                    w_entry.data[0] = i_byte;
                    n_hold          = HOLD_NONE;
                end
            end
        endcase
    end

    assign o_push      = w_accept && (w_entry.cnt != 2'd0);
    assign o_entry     = w_entry;
    assign o_stat.hold = r_hold;

endmodule

// ===== hdl/ped_queue.sv =====
`timescale 1ns / 1ps
module ped_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ped_pkg::t_entry i_entry,
    input  logic            i_pop,
    output ped_pkg::t_entry o_head,
    output ped_pkg::t_qstat o_stat
);
    import ped_pkg::*;

    t_entry            r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              w_push, w_pop;

    assign w_push = i_push && (r_count != QCNT_W'(QDEPTH));
    assign w_pop  = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    assign o_head       = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == QCNT_W'(QDEPTH));
    assign o_stat.count = r_count;

endmodule

// ===== hdl/ped_back.sv =====
`timescale 1ns / 1ps
module ped_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ped_pkg::t_entry i_head,
    input  logic            i_empty,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [7:0]      o_data,
    output logic            o_last
);
    import ped_pkg::*;

    t_entry     r_cur;
    logic [1:0] r_idx;
    logic       r_busy;
    logic       w_final;
    logic       w_take;

    assign w_final = (r_idx == (r_cur.cnt - 2'd1));
    assign w_take  = r_busy && i_ready;
    assign o_pop   = !i_empty && (!r_busy || (w_take && w_final));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (o_pop) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (w_take) begin
            if (w_final) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_head;
        end
    end

    assign o_valid = r_busy;
    assign o_data  = r_cur.data[r_idx];
    assign o_last  = r_cur.last && w_final;

endmodule

// ===== tb/ped_decode_checker.sv =====
`timescale 1ns / 1ps
module ped_decode_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] in_byte
    input  logic       i_s_tlast,
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,   // [7:0] out_byte
    input  logic       i_m_tlast,
    output int         o_fail_count,
    output int         o_pending
);
    import ped_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_decoded;

    t_decoded   decoded_q[$];
    t_decoded   expected;
    t_hold      hold_state;
    logic [7:0] held_byte;

    // The match flag sits in the top bit, the reserved character below it.
    function automatic logic [8:0] reserved_char(input logic [7:0] hi, input logic [7:0] lo);
        case ({hi, lo})
            "20": return {1'b1, 8'h20};
            "21": return {1'b1, 8'h21};
            "22": return {1'b1, 8'h22};
            "23": return {1'b1, 8'h23};
            "24": return {1'b1, 8'h24};
            "25": return {1'b1, 8'h25};
            "26": return {1'b1, 8'h26};
            "27": return {1'b1, 8'h27};
            "28": return {1'b1, 8'h28};
            "29": return {1'b1, 8'h29};
            "2A": return {1'b1, 8'h2A};
            "2B": return {1'b1, 8'h2B};
            "2C": return {1'b1, 8'h2C};
            "2F": return {1'b1, 8'h2F};
            "3A": return {1'b1, 8'h3A};
            "3B": return {1'b1, 8'h3B};
            "3D": return {1'b1, 8'h3D};
            "3F": return {1'b1, 8'h3F};
            "40": return {1'b1, 8'h40};
            "5B": return {1'b1, 8'h5B};
            "5D": return {1'b1, 8'h5D};
            default: return 9'd0;
        endcase
    endfunction

    task automatic push_decoded(input logic [7:0] data, input logic last);
        decoded_q.push_back('{data: data, last: last});
    endtask

    task automatic take_plain(input logic [7:0] data, input logic last);
        if (data == PERCENT_CHAR && !last) begin
            hold_state = HOLD_PCT;
        end else begin
            push_decoded(data, last);
            hold_state = HOLD_NONE;
        end
    endtask

    task automatic decode_request(input logic [7:0] data, input logic last);
        logic [8:0] esc;
        case (hold_state)
            HOLD_PCT: begin
                if (last) begin
                    push_decoded(PERCENT_CHAR, 1'b0);
                    push_decoded(data, 1'b1);
                    hold_state = HOLD_NONE;
                end else begin
                    held_byte  = data;
                    hold_state = HOLD_TWO;
                end
            end
            HOLD_TWO: begin
                esc = reserved_char(held_byte, data);
                if (esc[8]) begin
                    push_decoded(esc[7:0], last);
                    hold_state = HOLD_NONE;
                end else begin
                    push_decoded(PERCENT_CHAR, 1'b0);
                    if (held_byte == PERCENT_CHAR) begin
                        // The held '%' may open a new escape with this byte.
                        if (last) begin
                            push_decoded(PERCENT_CHAR, 1'b0);
                            push_decoded(data, 1'b1);
                            hold_state = HOLD_NONE;
                        end else begin
                            held_byte = data;
                        end
                    end else begin
                        push_decoded(held_byte, 1'b0);
                        take_plain(data, last);
                    end
                end
            end
            default: take_plain(data, last);
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            decoded_q.delete();
            hold_state   = HOLD_NONE;
            held_byte    = '0;
            o_fail_count = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (decoded_q.size() == 0) begin
                    $error("unexpected output request: out_byte %h out_last %b",
                           i_m_tdata, i_m_tlast);
                    o_fail_count++;
                end else begin
                    expected = decoded_q.pop_front();
                    if (i_m_tdata !== expected.data) begin
                        $error("out_byte: expected %h, got %h", expected.data, i_m_tdata);
                        o_fail_count++;
                    end
                    if (i_m_tlast !== expected.last) begin
                        $error("out_last: expected %b, got %b", expected.last, i_m_tlast);
                        o_fail_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                decode_request(i_s_tdata, i_s_tlast);
            end
        end
        o_pending = decoded_q.size();
    end

endmodule

// ===== tb/percent_escape_decoder_top_tb.sv =====
`timescale 1ns / 1ps
module percent_escape_decoder_top_tb;
    import ped_pkg::*;

    logic       i_clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;
    int         fail_count;
    int         pending;
    int         send_idle_pct;
    int         recv_idle_pct = 0;
    int         sent_count;

    percent_escape_decoder_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    ped_decode_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tlast    (s_tlast),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_byte(input logic [7:0] data, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = data;
        s_tlast  = last;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
        sent_count++;
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++) begin
            send_byte(text[i], i == text.len() - 1);
        end
    endtask

    task automatic send_random_string();
        logic [7:0] bytes[$];
        int         tokens;
        int         pick;
        int         idx;
        string      digits;
        digits = "0123456789ABCDEFabcdef%";
        tokens = $urandom_range(10, 1);
        for (int t = 0; t < tokens; t++) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                idx = $urandom_range(ESC_COUNT - 1);
                bytes.push_back(PERCENT_CHAR);
                bytes.push_back(ESC_HI[idx]);
                bytes.push_back(ESC_LO[idx]);
            end else if (pick < 58) begin
                bytes.push_back(PERCENT_CHAR);
                bytes.push_back(digits[$urandom_range(digits.len() - 1)]);
                bytes.push_back(digits[$urandom_range(digits.len() - 1)]);
            end else if (pick < 68) begin
                bytes.push_back(PERCENT_CHAR);
            end else begin
                bytes.push_back(8'($urandom_range(255)));
            end
        end
        for (int i = 0; i < bytes.size(); i++) begin
            send_byte(bytes[i], i == bytes.size() - 1);
        end
    endtask

    // Holds the sender off until every decoded byte has come out.
    task automatic drain();
        s_tvalid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    initial begin
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        send_idle_pct = 0;
        sent_count    = 0;
        repeat (8) @(negedge i_clk);
        rst_n = 1'b1;

        send_text("%20");
        send_text("%5D");
        send_text("%2a");
        send_text("%%3A");
        send_text("%");
        send_text("%4");
        send_text("A%3Fz");
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 38;
                    recv_idle_pct = 86;
                end
                1: begin
                    send_idle_pct = 86;
                    recv_idle_pct = 38;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            sent_count = 0;
            while (sent_count < 160) send_random_string();
            drain();
        end

        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
